// ===== src/iee_pkg.sv =====
package iee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_PLUS,
        OP_MINUS,
        OP_TIMES,
        OP_DIVIDE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_DIV_ZERO
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   start;
        logic                   is_div;
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
    } t_md_req;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [VALUE_WIDTH-1:0] result;
    } t_md_rsp;

    function automatic logic signed [31:0] to_out(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[31:0];
    endfunction

endpackage

// ===== src/iee_if.sv =====
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_expression;

    modport source (output valid, output char_code, output end_of_expression, input ready);
    modport sink   (input valid, input char_code, input end_of_expression, output ready);
endinterface

interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== src/iee_muldiv.sv =====
module iee_muldiv import iee_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_q, n_q;
    logic [W-1:0]     r_b, n_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done, r_div, r_neg;

    logic [W+1:0]     sum_x, sum_y, sum;
    logic [W-1:0]     abs_a, abs_b;

    assign abs_a = i_req.a[W-1] ? W'(-i_req.a) : i_req.a;
    assign abs_b = i_req.b[W-1] ? W'(-i_req.b) : i_req.b;

    // one shared adder: shift-add multiply or restoring divide step
    always_comb begin
        if (r_div) begin
            sum_x = {1'b0, r_acc, r_q[W-1]};
            sum_y = ~{2'b00, r_b};
        end else begin
            sum_x = {2'b00, r_acc};
            sum_y = {2'b00, r_q};
        end
        sum = sum_x + sum_y + (W+2)'(r_div);
    end

    always_comb begin
        n_acc = r_acc;
        n_q   = r_q;
        n_b   = r_b;
        if (i_req.start) begin
            n_acc = '0;
            n_q   = i_req.is_div ? abs_a : i_req.a;
            n_b   = i_req.is_div ? abs_b : i_req.b;
        end else if (r_busy) begin
            if (r_div) begin
                if (!sum[W+1]) begin
                    n_acc = sum[W-1:0];
                    n_q   = {r_q[W-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[W-2:0], r_q[W-1]};
                    n_q   = {r_q[W-2:0], 1'b0};
                end
            end else begin
                if (r_b[0]) begin
                    n_acc = sum[W-1:0];
                end
                n_q = {r_q[W-2:0], 1'b0};
                n_b = {1'b0, r_b[W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_q   <= n_q;
        r_b   <= n_b;
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_neg <= i_req.a[W-1] ^ i_req.b[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_div ? (r_neg ? W'(-r_q) : r_q) : r_acc;

endmodule

// ===== src/integer_expression_evaluator.sv =====
// channel   | dir | beat fields
// i_expr    | in  | char_code[7:0], end_of_expression
// o_result  | out | value[31:0] signed, status[1:0]
//
// digit, whitespace and invalid beats stay in S_IDLE; a +/- term passes S_FLUSH.
// a * or / term waits in S_WAIT on the shared one-bit-per-cycle multiply/divide
// unit; the end beat passes through S_DONE to post the result.
// i_rst_n, synchronous and active low, zeroes expression state but r_opnd, r_fop.
// the result sits in an output register; a new beat is taken while it waits,
// and only the next end beat holds until o_result is free.
module integer_expression_evaluator import iee_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iee_in_if.sink    i_expr,
    iee_out_if.source o_result
);

    localparam int W = VALUE_WIDTH;

    t_state         r_state, n_state;
    logic [W-1:0]   r_sum, n_sum;
    logic [W-1:0]   r_last, n_last;
    logic [W-1:0]   r_cur, n_cur;
    logic [W-1:0]   r_opnd, n_opnd;
    t_op            r_pend, n_pend;
    t_op            r_fop, n_fop;
    logic           r_prev_op, n_prev_op;
    logic           r_prev_slash, n_prev_slash;
    t_status        r_err, n_err;
    logic           r_divz, n_divz;
    logic           r_end, n_end;
    logic           r_out_valid;
    logic signed [31:0] r_value;
    t_status        r_status;

    t_md_req        md_req;
    t_md_rsp        md_rsp;

    logic [7:0]     c;
    logic [7:0]     digit_off;
    logic           is_space, is_digit, is_oper, active, ok;
    t_op            op_code;
    t_status        err_new;
    logic [W-1:0]   cur_new;
    logic           prev_op_new, flush_oper, flush_end, need_flush;
    logic           fire_in, fire_done, mul_path;
    logic [W-1:0]   total;
    t_status        status_fin;

    iee_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // character decode, error checks and digit accumulation
    always_comb begin
        c         = i_expr.char_code;
        digit_off = c - CH_ZERO;
        is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_oper   = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
        case (c)
            CH_PLUS:  op_code = OP_PLUS;
            CH_MINUS: op_code = OP_MINUS;
            CH_STAR:  op_code = OP_TIMES;
            default:  op_code = OP_DIVIDE;
        endcase

        active  = !is_space && (r_err == ST_OK);
        err_new = r_err;
        if (active) begin
            if (r_prev_op && is_oper) begin
                err_new = ST_INVALID;
            end else if (r_prev_slash && (c == CH_ZERO)) begin
                err_new = ST_DIV_ZERO;
            end else if (!is_oper && !is_digit) begin
                err_new = ST_INVALID;
            end
        end
        ok = active && (err_new == ST_OK);

        if (ok && is_digit) begin
            cur_new = {r_cur[W-4:0], 3'b000} + {r_cur[W-2:0], 1'b0} + W'(digit_off[3:0]);
        end else if (ok && is_oper) begin
            cur_new = '0;
        end else begin
            cur_new = r_cur;
        end

        prev_op_new = active ? is_oper : r_prev_op;
        flush_oper  = ok && is_oper;
        flush_end   = i_expr.end_of_expression && (err_new == ST_OK) && !prev_op_new;
        need_flush  = flush_oper || flush_end;
    end

    assign fire_in   = i_expr.valid && i_expr.ready;
    assign fire_done = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
    assign mul_path  = (r_fop == OP_TIMES) || ((r_fop == OP_DIVIDE) && (r_opnd != '0));
    assign total     = r_sum + r_last;

    always_comb begin
        if (r_err != ST_OK) begin
            status_fin = r_err;
        end else if (r_divz) begin
            status_fin = ST_DIV_ZERO;
        end else begin
            status_fin = ST_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (fire_in) begin
                    if (need_flush) begin
                        n_state = S_FLUSH;
                    end else if (i_expr.end_of_expression) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FLUSH: begin
                if (mul_path) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = r_end ? S_DONE : S_IDLE;
                end
            end
            S_WAIT: begin
                if (md_rsp.done) begin
                    n_state = r_end ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (fire_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_expr.ready  = 1'b0;
        md_req.start  = 1'b0;
        md_req.is_div = (r_fop == OP_DIVIDE);
        md_req.a      = r_last;
        md_req.b      = r_opnd;
        unique case (r_state)
            S_IDLE:  i_expr.ready = 1'b1;
            S_FLUSH: md_req.start = mul_path;
            S_WAIT:  md_req.start = 1'b0;
            S_DONE:  md_req.start = 1'b0;
            default: i_expr.ready = 1'b0;
        endcase
    end

    // expression datapath
    always_comb begin
        n_sum        = r_sum;
        n_last       = r_last;
        n_cur        = r_cur;
        n_opnd       = r_opnd;
        n_pend       = r_pend;
        n_fop        = r_fop;
        n_prev_op    = r_prev_op;
        n_prev_slash = r_prev_slash;
        n_err        = r_err;
        n_divz       = r_divz;
        n_end        = r_end;
        unique case (r_state)
            S_IDLE: begin
                if (fire_in) begin
                    n_err        = err_new;
                    n_cur        = cur_new;
                    n_prev_op    = prev_op_new;
                    n_prev_slash = active ? (c == CH_SLASH) : r_prev_slash;
                    n_pend       = flush_oper ? op_code : r_pend;
                    n_fop        = r_pend;
                    n_opnd       = flush_oper ? r_cur : cur_new;
                    n_end        = i_expr.end_of_expression;
                end
            end
            S_FLUSH: begin
                case (r_fop)
                    OP_PLUS: begin
                        n_sum  = total;
                        n_last = r_opnd;
                    end
                    OP_MINUS: begin
                        n_sum  = total;
                        n_last = W'(-r_opnd);
                    end
                    default: begin
                        if (!mul_path) begin
                            n_divz = 1'b1;
                            n_last = '0;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                if (md_rsp.done) begin
                    n_last = md_rsp.result;
                end
            end
            S_DONE: begin
                if (fire_done) begin
                    n_sum        = '0;
                    n_last       = '0;
                    n_cur        = '0;
                    n_pend       = OP_PLUS;
                    n_prev_op    = 1'b0;
                    n_prev_slash = 1'b0;
                    n_err        = ST_OK;
                    n_divz       = 1'b0;
                    n_end        = 1'b0;
                end
            end
            default: n_end = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sum        <= '0;
            r_last       <= '0;
            r_cur        <= '0;
            r_pend       <= OP_PLUS;
            r_prev_op    <= 1'b0;
            r_prev_slash <= 1'b0;
            r_err        <= ST_OK;
            r_divz       <= 1'b0;
            r_end        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sum        <= n_sum;
            r_last       <= n_last;
            r_cur        <= n_cur;
            r_pend       <= n_pend;
            r_prev_op    <= n_prev_op;
            r_prev_slash <= n_prev_slash;
            r_err        <= n_err;
            r_divz       <= n_divz;
            r_end        <= n_end;
            if (fire_done) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd <= n_opnd;
        r_fop  <= n_fop;
        if (fire_done) begin
            r_value  <= (status_fin == ST_OK) ? to_out(total) : '0;
            r_status <= status_fin;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.value  = r_value;
    assign o_result.status = r_status;

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("multiply/divide unit started while busy");

    a_wait_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (md_rsp.busy || md_rsp.done))
        else $error("waiting on an idle multiply/divide unit");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status != ST_OK)) |-> (o_result.value == '0))
        else $error("nonzero value with error status");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result posted outside done state");

endmodule
